>>> rtl/core/ecp_pkg.sv
// Shared types and constants for the expression character parser and ALU.
// No dependencies; imported by every module of the block.
`default_nettype none

package ecp_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NO_OP     = 3'd2,
        ST_NO_SECOND = 3'd3,
        ST_DIV_ZERO  = 3'd4,
        ST_BAD_OP    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Control part of one queued job; operands travel alongside
    typedef struct packed {
        t_status    status;
        t_op        op;
        logic [7:0] bad;
    } t_job_ctl;

endpackage

`default_nettype wire

>>> rtl/core/ecp_front.sv
// Front end: accepts characters one per cycle while i_take is high and parses the two operands and operator.
// Emits one job per terminator into the queue. Depends on ecp_pkg.
`default_nettype none

module ecp_front #(
    parameter int NUM_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_take,
    input  wire logic [7:0]             i_ch,
    output logic                        o_push,
    output ecp_pkg::t_job_ctl           o_ctl,
    output logic [NUM_WIDTH-1:0]        o_a,
    output logic [NUM_WIDTH-1:0]        o_b
);
    import ecp_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_NUM1,
        PH_SPACE1,
        PH_SPACE2,
        PH_NUM2,
        PH_IGNORE
    } t_phase;

    t_phase               r_phase;
    logic [NUM_WIDTH-1:0] r_mag1;
    logic [NUM_WIDTH-1:0] r_mag2;
    logic                 r_neg1;
    logic                 r_neg2;
    logic [7:0]           r_op_char;

    logic                 w_digit;
    logic [NUM_WIDTH-1:0] w_dval;
    logic [NUM_WIDTH-1:0] n_mag1;
    logic [NUM_WIDTH-1:0] n_mag2;

    always_comb begin
        w_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        w_dval  = NUM_WIDTH'(i_ch - CH_ZERO);
        n_mag1  = (r_mag1 << 3) + (r_mag1 << 1) + w_dval;
        n_mag2  = (r_mag2 << 3) + (r_mag2 << 1) + w_dval;
    end

    // Job built from the current parse state, pushed on the terminator
    always_comb begin
        o_push     = i_take && (i_ch == CH_NUL);
        o_a        = r_neg1 ? (NUM_WIDTH'(0) - r_mag1) : r_mag1;
        o_b        = r_neg2 ? (NUM_WIDTH'(0) - r_mag2) : r_mag2;
        o_ctl.op   = OP_ADD;
        o_ctl.bad  = 8'h00;
        unique case (r_phase)
            PH_START:             o_ctl.status = ST_EMPTY;
            PH_NUM1, PH_SPACE1:   o_ctl.status = ST_NO_OP;
            PH_SPACE2:            o_ctl.status = ST_NO_SECOND;
            default: begin
                o_ctl.status = ST_OK;
                case (r_op_char)
                    CH_PLUS:  o_ctl.op = OP_ADD;
                    CH_MINUS: o_ctl.op = OP_SUB;
                    CH_STAR:  o_ctl.op = OP_MUL;
                    CH_SLASH: o_ctl.op = OP_DIV;
                    default: begin
                        o_ctl.status = ST_BAD_OP;
                        o_ctl.bad    = r_op_char;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_mag1    <= '0;
            r_mag2    <= '0;
            r_neg1    <= 1'b0;
            r_neg2    <= 1'b0;
            r_op_char <= 8'h00;
        end else if (i_take) begin
            if (i_ch == CH_NUL) begin
                r_phase   <= PH_START;
                r_mag1    <= '0;
                r_mag2    <= '0;
                r_neg1    <= 1'b0;
                r_neg2    <= 1'b0;
                r_op_char <= 8'h00;
            end else begin
                unique case (r_phase)
                    PH_START: begin
                        if (i_ch == CH_MINUS) begin
                            r_neg1  <= 1'b1;
                            r_phase <= PH_NUM1;
                        end else if (i_ch == CH_PLUS) begin
                            r_phase <= PH_NUM1;
                        end else if (w_digit) begin
                            r_mag1  <= n_mag1;
                            r_phase <= PH_NUM1;
                        end else if (i_ch == CH_SPACE) begin
                            r_phase <= PH_SPACE1;
                        end else begin
                            r_op_char <= i_ch;
                            r_phase   <= PH_SPACE2;
                        end
                    end
                    PH_NUM1: begin
                        if (w_digit) begin
                            r_mag1 <= n_mag1;
                        end else if (i_ch == CH_SPACE) begin
                            r_phase <= PH_SPACE1;
                        end else begin
                            r_op_char <= i_ch;
                            r_phase   <= PH_SPACE2;
                        end
                    end
                    PH_SPACE1: begin
                        if (i_ch != CH_SPACE) begin
                            r_op_char <= i_ch;
                            r_phase   <= PH_SPACE2;
                        end
                    end
                    PH_SPACE2: begin
                        if (i_ch == CH_MINUS) begin
                            r_neg2  <= 1'b1;
                            r_phase <= PH_NUM2;
                        end else if (i_ch == CH_PLUS) begin
                            r_phase <= PH_NUM2;
                        end else if (w_digit) begin
                            r_mag2  <= n_mag2;
                            r_phase <= PH_NUM2;
                        end else if (i_ch != CH_SPACE) begin
                            r_phase <= PH_IGNORE;
                        end
                    end
                    PH_NUM2: begin
                        if (w_digit) begin
                            r_mag2 <= n_mag2;
                        end else begin
                            r_phase <= PH_IGNORE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ecp_queue.sv
// Two-entry job queue between the parser front end and the ALU back end.
// Depends on ecp_pkg for the queue depth.
`default_nettype none

module ecp_queue #(
    parameter int DATA_WIDTH = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [DATA_WIDTH-1:0] i_data,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output logic [DATA_WIDTH-1:0]      o_data
);
    import ecp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]         r_wp;
    logic [PW-1:0]         r_rp;
    logic [CW-1:0]         r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= PW'((r_wp + 1'b1) % QUEUE_DEPTH);
            end
            if (i_pop) begin
                r_rp <= PW'((r_rp + 1'b1) % QUEUE_DEPTH);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ecp_back.sv
// Back end: executes queued jobs; add/sub directly, shift-add multiply and
// restoring divide one bit per cycle, into a registered result slot. Depends on ecp_pkg.
`default_nettype none

module ecp_back #(
    parameter int NUM_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_job_valid,
    input  wire ecp_pkg::t_job_ctl      i_ctl,
    input  wire logic [NUM_WIDTH-1:0]   i_a,
    input  wire logic [NUM_WIDTH-1:0]   i_b,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [2:0]                  o_status,
    output logic signed [31:0]          o_value,
    output logic [7:0]                  o_bad_operator
);
    import ecp_pkg::*;

    localparam int CW = $clog2(NUM_WIDTH + 1);
    localparam int EW = (NUM_WIDTH > 32) ? NUM_WIDTH : 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_cnt;
    logic [NUM_WIDTH-1:0] r_x;
    logic [NUM_WIDTH-1:0] r_y;
    logic [NUM_WIDTH-1:0] r_acc;
    logic                 r_neg;
    logic                 r_ovalid;
    t_status              r_status;
    logic [31:0]          r_value;
    logic [7:0]           r_bad;

    logic                 w_out_free;
    logic                 w_iter;
    logic                 w_b_zero;
    logic [NUM_WIDTH-1:0] w_mag_a;
    logic [NUM_WIDTH-1:0] w_mag_b;
    logic [NUM_WIDTH-1:0] w_direct;
    logic [EW-1:0]        w_direct_ext;
    logic [NUM_WIDTH-1:0] w_mul_acc;
    logic [NUM_WIDTH:0]   w_div_t;
    logic                 w_div_ge;
    logic [NUM_WIDTH-1:0] w_div_rem;
    logic [NUM_WIDTH-1:0] w_final;
    logic [EW-1:0]        w_final_ext;
    logic                 w_done;
    logic                 w_load;

    always_comb begin
        w_out_free   = !r_ovalid || i_ready;
        w_b_zero     = (i_b == '0);
        w_iter       = (i_ctl.status == ST_OK) &&
                       ((i_ctl.op == OP_MUL) || ((i_ctl.op == OP_DIV) && !w_b_zero));
        w_mag_a      = i_a[NUM_WIDTH-1] ? (NUM_WIDTH'(0) - i_a) : i_a;
        w_mag_b      = i_b[NUM_WIDTH-1] ? (NUM_WIDTH'(0) - i_b) : i_b;
        w_direct     = (i_ctl.op == OP_SUB) ? (i_a - i_b) : (i_a + i_b);
        w_direct_ext = EW'(w_direct);

        w_mul_acc    = r_acc + (r_y[0] ? r_x : '0);
        w_div_t      = {r_acc, r_x[NUM_WIDTH-1]};
        w_div_ge     = (w_div_t >= {1'b0, r_y});
        w_div_rem    = w_div_ge ? NUM_WIDTH'(w_div_t - {1'b0, r_y})
                                : w_div_t[NUM_WIDTH-1:0];

        w_final      = (r_state == S_MUL) ? r_acc
                                          : (r_neg ? (NUM_WIDTH'(0) - r_x) : r_x);
        w_final_ext  = EW'(w_final);
        w_done       = (r_cnt == CW'(NUM_WIDTH));

        o_pop        = (r_state == S_IDLE) && i_job_valid && (w_iter || w_out_free);

        // result slot is loaded this cycle
        w_load       = ((r_state == S_IDLE) && i_job_valid && !w_iter && w_out_free) ||
                       (((r_state == S_MUL) || (r_state == S_DIV)) && w_done && w_out_free);
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_value        = r_value;
    assign o_bad_operator = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid && w_iter) begin
                        r_cnt <= '0;
                        r_acc <= '0;
                        if (i_ctl.op == OP_MUL) begin
                            r_x     <= i_a;
                            r_y     <= i_b;
                            r_state <= S_MUL;
                        end else begin
                            r_x     <= w_mag_a;
                            r_y     <= w_mag_b;
                            r_neg   <= i_a[NUM_WIDTH-1] ^ i_b[NUM_WIDTH-1];
                            r_state <= S_DIV;
                        end
                    end else if (i_job_valid && w_out_free) begin
                        r_bad    <= i_ctl.bad;
                        r_value  <= 32'h0;
                        if (i_ctl.status != ST_OK) begin
                            r_status <= i_ctl.status;
                        end else if (i_ctl.op == OP_DIV) begin
                            r_status <= ST_DIV_ZERO;
                        end else begin
                            r_status <= ST_OK;
                            r_value  <= w_direct_ext[31:0];
                        end
                    end
                end
                S_MUL, S_DIV: begin
                    if (!w_done) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_state == S_MUL) begin
                            r_acc <= w_mul_acc;
                            r_x   <= r_x << 1;
                            r_y   <= r_y >> 1;
                        end else begin
                            r_acc <= w_div_rem;
                            r_x   <= {r_x[NUM_WIDTH-2:0], w_div_ge};
                        end
                    end else if (w_out_free) begin
                        r_status <= ST_OK;
                        r_value  <= w_final_ext[31:0];
                        r_bad    <= 8'h00;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/expression_char_parser_alu.sv
// Top level of the character-serial expression evaluator: parser front end,
// two-entry job queue and ALU back end. Depends on ecp_pkg, ecp_front, ecp_queue, ecp_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  char    | in        | i_valid / o_ready  | i_ch[7:0]
//  result  | out       | o_valid / i_ready  | o_status[2:0], o_value[31:0], o_bad_operator
//
// Characters are taken one per cycle. A terminator pushes one job into the queue; add,
// subtract and all error results go straight from the queue head into the result slot,
// multiply and divide pass through the bit-serial back end. The front keeps taking characters
// while the back works, stalling only when the queue holds two jobs.
// Synchronous active-low reset clears parser, queue, back end state and the result valid flag.
`default_nettype none

module expression_char_parser_alu #(
    parameter int NUM_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_ch,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_value,
    output logic [7:0]         o_bad_operator
);
    import ecp_pkg::*;

    localparam int CTL_W = $bits(t_job_ctl);
    localparam int JOB_W = CTL_W + 2 * NUM_WIDTH;

    logic                 w_take;
    logic                 w_push;
    t_job_ctl             w_push_ctl;
    logic [NUM_WIDTH-1:0] w_push_a;
    logic [NUM_WIDTH-1:0] w_push_b;
    logic                 w_q_full;
    logic                 w_q_valid;
    logic                 w_pop;
    logic [JOB_W-1:0]     w_q_data;
    t_job_ctl             w_head_ctl;
    logic [NUM_WIDTH-1:0] w_head_a;
    logic [NUM_WIDTH-1:0] w_head_b;

    assign o_ready    = !w_q_full;
    assign w_take     = i_valid && !w_q_full;
    assign w_head_ctl = t_job_ctl'(w_q_data[JOB_W-1 -: CTL_W]);
    assign w_head_a   = w_q_data[2*NUM_WIDTH-1 -: NUM_WIDTH];
    assign w_head_b   = w_q_data[NUM_WIDTH-1:0];

    ecp_front #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_ch    (i_ch),
        .o_push  (w_push),
        .o_ctl   (w_push_ctl),
        .o_a     (w_push_a),
        .o_b     (w_push_b)
    );

    ecp_queue #(
        .DATA_WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_ctl, w_push_a, w_push_b}),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    ecp_back #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_q_valid),
        .i_ctl          (w_head_ctl),
        .i_a            (w_head_a),
        .i_b            (w_head_b),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_value        (o_value),
        .o_bad_operator (o_bad_operator)
    );

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_value == 32'sd0))
        else $error("non-zero value on error result");

    a_bad_only_on_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_BAD_OP) |-> (o_bad_operator == 8'h00))
        else $error("operator character reported without bad-operator status");

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("back end popped an empty queue");

    a_full_holds_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full && !w_pop |=> w_q_full)
        else $error("queue lost a job while full");

endmodule

`default_nettype wire
